// ===== rtl/core/line_error_test_statistics_macros.svh =====
// Assertion macros shared by the line error test statistics RTL.
`ifndef LINE_ERROR_TEST_STATISTICS_MACROS_SVH
`define LINE_ERROR_TEST_STATISTICS_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LETS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LETS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lets_pkg.sv =====
// Shared widths, codes, types and helpers for the line error test statistics block.
package lets_pkg;

  localparam int ACT_WIDTH   = 3;
  localparam int DUR_WIDTH   = 14;
  localparam int ERROR_WIDTH = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int SUM_WIDTH   = 32;
  localparam int MEAN_WIDTH  = 16;

  // Action codes; codes above READ behave as a read.
  localparam logic [ACT_WIDTH-1:0] ACT_START  = ACT_WIDTH'(0);
  localparam logic [ACT_WIDTH-1:0] ACT_SAMPLE = ACT_WIDTH'(1);
  localparam logic [ACT_WIDTH-1:0] ACT_TICK   = ACT_WIDTH'(2);
  localparam logic [ACT_WIDTH-1:0] ACT_STOP   = ACT_WIDTH'(3);
  localparam logic [ACT_WIDTH-1:0] ACT_READ   = ACT_WIDTH'(4);

  localparam logic [DUR_WIDTH-1:0] MIN_DURATION_MS = DUR_WIDTH'(200);
  localparam logic [DUR_WIDTH-1:0] MAX_DURATION_MS = DUR_WIDTH'(10000);
  localparam logic [DUR_WIDTH-1:0] ELAPSED_MAX     = {DUR_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX     = {COUNT_WIDTH{1'b1}};

  // The mean never exceeds the largest possible absolute error.
  localparam logic [SUM_WIDTH-1:0] MEAN_CAP = SUM_WIDTH'(1) << (ERROR_WIDTH - 1);

  // Divider runs one quotient bit per cycle over the whole sum.
  localparam int DIV_STEPS = SUM_WIDTH;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Per-transaction flags produced by the statistics update.
  typedef struct packed {
    logic status;
    logic done;
  } lets_evt_t;

  // Snapshot of the statistics registers.
  typedef struct packed {
    logic                          active;
    logic                          completed;
    logic [COUNT_WIDTH-1:0]        taken;
    logic [COUNT_WIDTH-1:0]        found;
    logic [COUNT_WIDTH-1:0]        lost;
    logic [COUNT_WIDTH-1:0]        crossings;
    logic [SUM_WIDTH-1:0]          abs_total;
    logic signed [ERROR_WIDTH-1:0] smallest;
    logic signed [ERROR_WIDTH-1:0] largest;
  } lets_snap_t;

  // Saturating increment of a count.
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + COUNT_WIDTH'(1);
  endfunction

endpackage

// ===== rtl/core/lets_stats.sv =====
// Statistics registers and their per-action update.
module lets_stats (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     accept,
  input  logic [lets_pkg::ACT_WIDTH-1:0]           action,
  input  logic [lets_pkg::DUR_WIDTH-1:0]           length_ms,
  input  logic                                     line_found,
  input  logic signed [lets_pkg::ERROR_WIDTH-1:0]  error_sample,
  output lets_pkg::lets_evt_t                      evt,
  output lets_pkg::lets_snap_t                     snap
);

  localparam int EW = lets_pkg::ERROR_WIDTH;
  localparam int SW = lets_pkg::SUM_WIDTH;

  logic                                 armed_r, armed_nxt;
  logic                                 finished_r, finished_nxt;
  logic [lets_pkg::DUR_WIDTH-1:0]       elapsed_r, elapsed_nxt;
  logic [lets_pkg::DUR_WIDTH-1:0]       length_r, length_nxt;
  logic [lets_pkg::COUNT_WIDTH-1:0]     taken_r, taken_nxt;
  logic [lets_pkg::COUNT_WIDTH-1:0]     found_r, found_nxt;
  logic [lets_pkg::COUNT_WIDTH-1:0]     lost_r, lost_nxt;
  logic [lets_pkg::COUNT_WIDTH-1:0]     cross_r, cross_nxt;
  logic [SW-1:0]                        sum_r, sum_nxt;
  logic signed [EW-1:0]                 min_r, min_nxt;
  logic signed [EW-1:0]                 max_r, max_nxt;
  logic signed [EW-1:0]                 last_r, last_nxt;

  logic [EW:0]                          err_ext;
  logic [EW:0]                          mag;
  logic [SW:0]                          sum_wide;
  logic [SW-1:0]                        sum_sat;
  logic [lets_pkg::DUR_WIDTH-1:0]       elapsed_inc;
  logic                                 dur_bad;
  logic                                 e_neg, e_pos, last_neg, last_pos;

  // Magnitude of the error and the saturated running sum.
  assign err_ext     = {error_sample[EW-1], error_sample};
  assign mag         = err_ext[EW] ? (~err_ext + (EW+1)'(1)) : err_ext;
  assign sum_wide    = {1'b0, sum_r} + (SW+1)'(mag);
  assign sum_sat     = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
  assign elapsed_inc = (elapsed_r == lets_pkg::ELAPSED_MAX) ? elapsed_r
                                                            : elapsed_r + 1'b1;
  assign dur_bad     = (length_ms < lets_pkg::MIN_DURATION_MS) ||
                       (length_ms > lets_pkg::MAX_DURATION_MS);
  assign e_neg       = error_sample[EW-1];
  assign e_pos       = !error_sample[EW-1] && (error_sample != '0);
  assign last_neg    = last_r[EW-1];
  assign last_pos    = !last_r[EW-1] && (last_r != '0);

  // Next state for the accepted action.
  always_comb begin
    armed_nxt    = armed_r;
    finished_nxt = finished_r;
    elapsed_nxt  = elapsed_r;
    length_nxt   = length_r;
    taken_nxt    = taken_r;
    found_nxt    = found_r;
    lost_nxt     = lost_r;
    cross_nxt    = cross_r;
    sum_nxt      = sum_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    last_nxt     = last_r;
    evt.status   = 1'b0;
    evt.done     = 1'b0;
    unique case (action)
      lets_pkg::ACT_START: begin
        if (dur_bad) begin
          evt.status = 1'b1;
        end else begin
          taken_nxt    = '0;
          found_nxt    = '0;
          lost_nxt     = '0;
          cross_nxt    = '0;
          sum_nxt      = '0;
          min_nxt      = '0;
          max_nxt      = '0;
          last_nxt     = '0;
          length_nxt   = length_ms;
          elapsed_nxt  = '0;
          finished_nxt = 1'b0;
          armed_nxt    = 1'b1;
        end
      end
      lets_pkg::ACT_SAMPLE: begin
        if (armed_r) begin
          taken_nxt = lets_pkg::sat_inc(taken_r);
          if (!line_found) begin
            lost_nxt = lets_pkg::sat_inc(lost_r);
          end else begin
            sum_nxt = sum_sat;
            if (found_r == '0) begin
              min_nxt = error_sample;
              max_nxt = error_sample;
            end else begin
              if (error_sample < min_r) min_nxt = error_sample;
              if (error_sample > max_r) max_nxt = error_sample;
              if ((e_neg && last_pos) || (e_pos && last_neg)) begin
                cross_nxt = lets_pkg::sat_inc(cross_r);
              end
            end
            last_nxt  = error_sample;
            found_nxt = lets_pkg::sat_inc(found_r);
          end
        end
      end
      lets_pkg::ACT_TICK: begin
        if (armed_r) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= length_r) begin
            armed_nxt    = 1'b0;
            finished_nxt = 1'b1;
            evt.done     = 1'b1;
          end
        end
      end
      lets_pkg::ACT_STOP: begin
        armed_nxt = 1'b0;
      end
      default: begin
        // Read and unused codes leave the state alone.
      end
    endcase
  end

  // Control flags, counters and error statistics.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r    <= 1'b0;
      finished_r <= 1'b0;
      elapsed_r  <= '0;
      length_r   <= '0;
      taken_r    <= '0;
      found_r    <= '0;
      lost_r     <= '0;
      cross_r    <= '0;
      sum_r      <= '0;
      min_r      <= '0;
      max_r      <= '0;
      last_r     <= '0;
    end else if (accept) begin
      armed_r    <= armed_nxt;
      finished_r <= finished_nxt;
      elapsed_r  <= elapsed_nxt;
      length_r   <= length_nxt;
      taken_r    <= taken_nxt;
      found_r    <= found_nxt;
      lost_r     <= lost_nxt;
      cross_r    <= cross_nxt;
      sum_r      <= sum_nxt;
      min_r      <= min_nxt;
      max_r      <= max_nxt;
      last_r     <= last_nxt;
    end
  end

  // Snapshot of the stored statistics.
  assign snap.active    = armed_r;
  assign snap.completed = finished_r;
  assign snap.taken     = taken_r;
  assign snap.found     = found_r;
  assign snap.lost      = lost_r;
  assign snap.crossings = cross_r;
  assign snap.abs_total = sum_r;
  assign snap.smallest  = min_r;
  assign snap.largest   = max_r;

endmodule

// ===== rtl/core/lets_div.sv =====
// Bit-serial restoring divider for the mean absolute error.
`include "line_error_test_statistics_macros.svh"

module lets_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [lets_pkg::SUM_WIDTH-1:0]      dividend,
  input  logic [lets_pkg::COUNT_WIDTH-1:0]    divisor,
  output logic                                done,
  output logic [lets_pkg::MEAN_WIDTH-1:0]     mean
);

  localparam int SW = lets_pkg::SUM_WIDTH;
  localparam int CW = lets_pkg::COUNT_WIDTH;
  localparam logic [lets_pkg::DIV_CNT_W-1:0] LAST_STEP =
    lets_pkg::DIV_CNT_W'(lets_pkg::DIV_STEPS - 1);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic                           zero_r;
  logic [lets_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]                  div_r;
  logic [CW-1:0]                  rem_r, rem_nxt;
  logic [SW-1:0]                  quo_r, quo_nxt;
  logic [CW:0]                    trial;
  logic [CW:0]                    diff;
  logic                           fits;

  // One trial subtraction per cycle; the dividend shifts out as quotient shifts in.
  assign trial = {rem_r, quo_r[SW-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = (trial >= {1'b0, div_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      rem_nxt = fits ? diff[CW-1:0] : trial[CW-1:0];
      quo_nxt = {quo_r[SW-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Sequencing flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand and shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      div_r  <= divisor;
      zero_r <= (divisor == '0);
      rem_r  <= '0;
      quo_r  <= dividend;
    end else begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
    end
  end

  // Clamp the quotient; no found samples gives zero.
  always_comb begin
    priority if (zero_r) begin
      mean = '0;
    end else if (quo_r > lets_pkg::MEAN_CAP) begin
      mean = lets_pkg::MEAN_CAP[lets_pkg::MEAN_WIDTH-1:0];
    end else begin
      mean = quo_r[lets_pkg::MEAN_WIDTH-1:0];
    end
  end

  assign done = done_r;

  `LETS_ASSERT_IMP(a_no_start_busy, start, !busy_r, "divider started while busy")
  `LETS_ASSERT_IMP(a_rem_bound, busy_r && !zero_r, rem_r < div_r, "remainder not below divisor")
  `LETS_ASSERT_NXT(a_last_step, busy_r && (cnt_r == LAST_STEP) && !start, done_r && !busy_r, "divider did not finish")

endmodule

// ===== rtl/core/line_error_test_statistics.sv =====
// Top level of the line error test statistics block.
//
// Input channel: in_valid/in_stall with in_action, in_length_ms, in_line_found and
// in_error_sample. A transaction is taken when in_valid is high and in_stall is low.
// Result channel: out_valid/out_stall with one snapshot per input transaction.
// The statistics update at the input edge; a bit-serial divider then forms the mean
// absolute error one quotient bit per cycle over the 32-bit sum.
// An accepted input passes through ST_START, the divider steps over the whole sum, the
// capture of the quotient and ST_LOAD, which loads the output register once it is free.
// One transaction is in work at a time; the block returns to idle to accept the next.
// in_stall is low only while the block is idle. The output register holds a result
// while the next transaction is accepted; if the receiver stalls longer than the
// next result takes, that result waits and in_stall stays high.
// Synchronous reset (rst_n low) clears every statistic, disarms the test and drops
// out_valid. A stalled result holds its payload until taken.
`include "line_error_test_statistics_macros.svh"

module line_error_test_statistics (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [lets_pkg::ACT_WIDTH-1:0]           in_action,
  input  logic [lets_pkg::DUR_WIDTH-1:0]           in_length_ms,
  input  logic                                     in_line_found,
  input  logic signed [lets_pkg::ERROR_WIDTH-1:0]  in_error_sample,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic                                     out_status,
  output logic                                     out_test_active,
  output logic                                     out_test_completed,
  output logic                                     out_done_event,
  output logic [lets_pkg::COUNT_WIDTH-1:0]         out_samples_taken,
  output logic [lets_pkg::COUNT_WIDTH-1:0]         out_samples_found,
  output logic [lets_pkg::COUNT_WIDTH-1:0]         out_samples_lost,
  output logic [lets_pkg::COUNT_WIDTH-1:0]         out_sign_crossings,
  output logic [lets_pkg::SUM_WIDTH-1:0]           out_absolute_error_total,
  output logic signed [lets_pkg::ERROR_WIDTH-1:0]  out_smallest_error,
  output logic signed [lets_pkg::ERROR_WIDTH-1:0]  out_largest_error,
  output logic [lets_pkg::MEAN_WIDTH-1:0]          out_mean_absolute_error
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_LOAD  = 2'd3;

  logic [1:0]                         state_r, state_nxt;
  logic                               in_take;
  logic                               out_free;
  logic                               load;
  logic                               div_done;
  logic [lets_pkg::MEAN_WIDTH-1:0]    div_mean;
  logic [lets_pkg::MEAN_WIDTH-1:0]    mean_r;
  lets_pkg::lets_evt_t                evt;
  lets_pkg::lets_evt_t                evt_r;
  lets_pkg::lets_snap_t               snap;
  logic                               out_valid_r;
  lets_pkg::lets_evt_t                out_evt_r;
  lets_pkg::lets_snap_t               out_snap_r;
  logic [lets_pkg::MEAN_WIDTH-1:0]    out_mean_r;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign load     = (state_r == ST_LOAD) && out_free;

  lets_stats u_stats (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_take),
    .action       (in_action),
    .length_ms    (in_length_ms),
    .line_found   (in_line_found),
    .error_sample (in_error_sample),
    .evt          (evt),
    .snap         (snap)
  );

  lets_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_START),
    .dividend (snap.abs_total),
    .divisor  (snap.found),
    .done     (div_done),
    .mean     (div_mean)
  );

  // Transaction sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_take) state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_LOAD;
      ST_LOAD:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-transaction flags, quotient and the output register.
  always_ff @(posedge clk) begin
    if (in_take) evt_r <= evt;
    if (div_done) mean_r <= div_mean;
    if (load) begin
      out_evt_r  <= evt_r;
      out_snap_r <= snap;
      out_mean_r <= mean_r;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_status               = out_evt_r.status;
  assign out_done_event           = out_evt_r.done;
  assign out_test_active          = out_snap_r.active;
  assign out_test_completed       = out_snap_r.completed;
  assign out_samples_taken        = out_snap_r.taken;
  assign out_samples_found        = out_snap_r.found;
  assign out_samples_lost         = out_snap_r.lost;
  assign out_sign_crossings       = out_snap_r.crossings;
  assign out_absolute_error_total = out_snap_r.abs_total;
  assign out_smallest_error       = out_snap_r.smallest;
  assign out_largest_error        = out_snap_r.largest;
  assign out_mean_absolute_error  = out_mean_r;

  `LETS_ASSERT_NXT(a_take_starts_div, in_take, state_r == ST_START, "accepted item did not start")
  `LETS_ASSERT_IMP(a_done_in_div, div_done, state_r == ST_DIV, "divider result outside wait")
  `LETS_ASSERT_NXT(a_out_hold, out_valid_r && out_stall, out_valid_r, "stalled result dropped")

endmodule

// ===== dv/line_error_test_statistics_tb.sv =====
// Self-checking testbench for the line error test statistics block.
module line_error_test_statistics_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lets_pkg::*;

  // Spare action codes, which the block handles as a read.
  localparam logic [ACT_WIDTH-1:0] ACT_UNUSED_5 = ACT_WIDTH'(5);
  localparam logic [ACT_WIDTH-1:0] ACT_UNUSED_6 = ACT_WIDTH'(6);
  localparam logic [ACT_WIDTH-1:0] ACT_UNUSED_7 = ACT_WIDTH'(7);

  localparam int RANDOM_ITEMS   = 1750;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 80;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int MAX_REPORTS    = 10;
  localparam longint unsigned SUM_CEILING = (64'd1 << SUM_WIDTH) - 64'd1;

  // One snapshot as the result channel carries it.
  typedef struct packed {
    logic                          status;
    logic                          active;
    logic                          completed;
    logic                          done_evt;
    logic [COUNT_WIDTH-1:0]        taken;
    logic [COUNT_WIDTH-1:0]        found;
    logic [COUNT_WIDTH-1:0]        lost;
    logic [COUNT_WIDTH-1:0]        crossings;
    logic [SUM_WIDTH-1:0]          abs_total;
    logic signed [ERROR_WIDTH-1:0] smallest;
    logic signed [ERROR_WIDTH-1:0] largest;
    logic [MEAN_WIDTH-1:0]         mean;
  } snapshot_t;

  // Where the expected snapshot of an opening row comes from.
  typedef enum logic [1:0] {
    CHECK_MODEL,
    CHECK_IDLE,
    CHECK_REJECT,
    CHECK_ARMED
  } check_kind_t;

  typedef struct {
    logic [ACT_WIDTH-1:0]          action;
    logic [DUR_WIDTH-1:0]          duration;
    logic                          line_found;
    logic signed [ERROR_WIDTH-1:0] error;
    check_kind_t                   check;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ACT_WIDTH-1:0] in_action = ACT_READ;
  logic [DUR_WIDTH-1:0] in_length_ms = '0;
  logic in_line_found = 1'b0;
  logic signed [ERROR_WIDTH-1:0] in_error_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_status;
  logic out_test_active;
  logic out_test_completed;
  logic out_done_event;
  logic [COUNT_WIDTH-1:0] out_samples_taken;
  logic [COUNT_WIDTH-1:0] out_samples_found;
  logic [COUNT_WIDTH-1:0] out_samples_lost;
  logic [COUNT_WIDTH-1:0] out_sign_crossings;
  logic [SUM_WIDTH-1:0] out_absolute_error_total;
  logic signed [ERROR_WIDTH-1:0] out_smallest_error;
  logic signed [ERROR_WIDTH-1:0] out_largest_error;
  logic [MEAN_WIDTH-1:0] out_mean_absolute_error;

  // Predicted test state and statistics.
  logic run_armed = 1'b0;
  logic run_finished = 1'b0;
  logic [DUR_WIDTH-1:0] run_elapsed = '0;
  logic [DUR_WIDTH-1:0] run_length = '0;
  logic [COUNT_WIDTH-1:0] cnt_taken = '0;
  logic [COUNT_WIDTH-1:0] cnt_found = '0;
  logic [COUNT_WIDTH-1:0] cnt_lost = '0;
  logic [COUNT_WIDTH-1:0] cnt_crossings = '0;
  logic [SUM_WIDTH-1:0] err_sum = '0;
  logic signed [ERROR_WIDTH-1:0] err_min = '0;
  logic signed [ERROR_WIDTH-1:0] err_max = '0;
  logic signed [ERROR_WIDTH-1:0] err_last = '0;

  snapshot_t pending_snapshots[$];
  int mismatch_count = 0;
  int result_index = 0;
  int cycle_count = 0;
  int starts_taken = 0;
  int starts_refused = 0;
  int tests_completed = 0;
  int found_recorded = 0;
  bit hold_request = 1'b0;
  bit steady_flow = 1'b0;

  // Opening rows: empty reads, refused durations, restarts, extreme errors and spare codes.
  plan_row_t opening_plan [26] = '{
    '{ACT_READ,     14'd0,                   1'b0, 16'sh0000, CHECK_IDLE},
    '{ACT_SAMPLE,   14'd0,                   1'b1, 16'sh7FFF, CHECK_IDLE},
    '{ACT_TICK,     14'd0,                   1'b0, 16'sh0000, CHECK_IDLE},
    '{ACT_STOP,     14'd0,                   1'b0, 16'sh0000, CHECK_IDLE},
    '{ACT_START,    MIN_DURATION_MS - 1'b1,  1'b0, 16'sh0000, CHECK_REJECT},
    '{ACT_START,    MAX_DURATION_MS + 1'b1,  1'b0, 16'sh0000, CHECK_REJECT},
    '{ACT_START,    14'd0,                   1'b0, 16'sh0000, CHECK_REJECT},
    '{ACT_START,    14'h3FFF,                1'b1, 16'shFFFF, CHECK_REJECT},
    '{ACT_START,    MAX_DURATION_MS,         1'b1, 16'sh8000, CHECK_ARMED},
    '{ACT_START,    MIN_DURATION_MS,         1'b0, 16'sh0000, CHECK_ARMED},
    '{ACT_SAMPLE,   14'd0,                   1'b1, 16'sh7FFF, CHECK_MODEL},
    '{ACT_SAMPLE,   14'd0,                   1'b1, 16'sh8000, CHECK_MODEL},
    '{ACT_SAMPLE,   14'd0,                   1'b0, 16'sh1234, CHECK_MODEL},
    '{ACT_SAMPLE,   14'd0,                   1'b1, 16'sh0000, CHECK_MODEL},
    '{ACT_SAMPLE,   14'd0,                   1'b1, 16'sh0001, CHECK_MODEL},
    '{ACT_SAMPLE,   14'd0,                   1'b1, 16'shFFFF, CHECK_MODEL},
    '{ACT_SAMPLE,   14'd0,                   1'b1, 16'shFFFF, CHECK_MODEL},
    '{ACT_TICK,     14'd0,                   1'b0, 16'sh0000, CHECK_MODEL},
    '{ACT_UNUSED_5, 14'h3FFF,                1'b1, 16'sh7FFF, CHECK_MODEL},
    '{ACT_UNUSED_6, 14'd0,                   1'b0, 16'sh0000, CHECK_MODEL},
    '{ACT_UNUSED_7, 14'd0,                   1'b1, 16'sh8000, CHECK_MODEL},
    '{ACT_STOP,     14'd0,                   1'b0, 16'sh0000, CHECK_MODEL},
    '{ACT_TICK,     14'd0,                   1'b0, 16'sh0000, CHECK_MODEL},
    '{ACT_SAMPLE,   14'd0,                   1'b1, 16'sh0064, CHECK_MODEL},
    '{ACT_START,    MIN_DURATION_MS,         1'b0, 16'sh0000, CHECK_ARMED},
    '{ACT_READ,     14'd0,                   1'b0, 16'sh0000, CHECK_MODEL}
  };

  line_error_test_statistics u_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_action                (in_action),
    .in_length_ms             (in_length_ms),
    .in_line_found            (in_line_found),
    .in_error_sample          (in_error_sample),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_status               (out_status),
    .out_test_active          (out_test_active),
    .out_test_completed       (out_test_completed),
    .out_done_event           (out_done_event),
    .out_samples_taken        (out_samples_taken),
    .out_samples_found        (out_samples_found),
    .out_samples_lost         (out_samples_lost),
    .out_sign_crossings       (out_sign_crossings),
    .out_absolute_error_total (out_absolute_error_total),
    .out_smallest_error       (out_smallest_error),
    .out_largest_error        (out_largest_error),
    .out_mean_absolute_error  (out_mean_absolute_error)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [COUNT_WIDTH-1:0] count_up(input logic [COUNT_WIDTH-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  // Advances the predicted state by one action and returns the snapshot it produces.
  function automatic snapshot_t predict_snapshot(input logic [ACT_WIDTH-1:0] act,
                                                 input logic [DUR_WIDTH-1:0] dur,
                                                 input logic found,
                                                 input logic signed [ERROR_WIDTH-1:0] err);
    snapshot_t snap;
    longint unsigned mag;
    longint unsigned widened;
    longint unsigned quotient;
    snap = '0;
    case (act)
      ACT_START: begin
        if (dur < MIN_DURATION_MS || dur > MAX_DURATION_MS) begin
          snap.status = 1'b1;
          starts_refused++;
        end else begin
          cnt_taken = '0;
          cnt_found = '0;
          cnt_lost = '0;
          cnt_crossings = '0;
          err_sum = '0;
          err_min = '0;
          err_max = '0;
          err_last = '0;
          run_length = dur;
          run_elapsed = '0;
          run_finished = 1'b0;
          run_armed = 1'b1;
          starts_taken++;
        end
      end
      ACT_SAMPLE: begin
        if (run_armed) begin
          cnt_taken = count_up(cnt_taken);
          if (!found) begin
            cnt_lost = count_up(cnt_lost);
          end else begin
            mag = (err < 0) ? -longint'(err) : longint'(err);
            widened = longint'(err_sum) + mag;
            err_sum = (widened > SUM_CEILING) ? '1 : widened[SUM_WIDTH-1:0];
            if (cnt_found == '0) begin
              err_min = err;
              err_max = err;
            end else begin
              if (err < err_min) err_min = err;
              if (err > err_max) err_max = err;
              // A crossing needs strictly opposite signs; zero breaks the chain.
              if ((err < 0 && err_last > 0) || (err > 0 && err_last < 0)) begin
                cnt_crossings = count_up(cnt_crossings);
              end
            end
            err_last = err;
            cnt_found = count_up(cnt_found);
            found_recorded++;
          end
        end
      end
      ACT_TICK: begin
        if (run_armed) begin
          if (run_elapsed != ELAPSED_MAX) run_elapsed = run_elapsed + 1'b1;
          if (run_elapsed >= run_length) begin
            run_armed = 1'b0;
            run_finished = 1'b1;
            snap.done_evt = 1'b1;
            tests_completed++;
          end
        end
      end
      ACT_STOP: begin
        run_armed = 1'b0;
      end
      default: begin
      end
    endcase

    snap.active = run_armed;
    snap.completed = run_finished;
    snap.taken = cnt_taken;
    snap.found = cnt_found;
    snap.lost = cnt_lost;
    snap.crossings = cnt_crossings;
    snap.abs_total = err_sum;
    snap.smallest = err_min;
    snap.largest = err_max;
    // Mean is truncated and clamped to the largest possible magnitude.
    if (cnt_found != '0) begin
      quotient = longint'(err_sum) / longint'(cnt_found);
      if (quotient > longint'(MEAN_CAP)) quotient = longint'(MEAN_CAP);
      snap.mean = quotient[MEAN_WIDTH-1:0];
    end
    return snap;
  endfunction

  // Snapshot written out by hand for the simple opening rows.
  function automatic snapshot_t typed_snapshot(input check_kind_t kind);
    snapshot_t snap;
    snap = '0;
    if (kind == CHECK_REJECT) snap.status = 1'b1;
    if (kind == CHECK_ARMED) snap.active = 1'b1;
    return snap;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("[tb] result %0d, %s: expected 0x%0h, got 0x%0h",
                              result_index, name, want, got));
    end
  endtask

  // Offers one transaction, records its expected snapshot when taken, then may idle for a random gap.
  task automatic offer_transaction(input logic [ACT_WIDTH-1:0] act,
                                   input logic [DUR_WIDTH-1:0] dur,
                                   input logic found,
                                   input logic signed [ERROR_WIDTH-1:0] err,
                                   input check_kind_t kind);
    snapshot_t predicted;
    int roll;
    int gap;
    in_valid <= 1'b1;
    in_action <= act;
    in_length_ms <= dur;
    in_line_found <= found;
    in_error_sample <= err;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_snapshot(act, dur, found, err);
    if (kind == CHECK_MODEL) pending_snapshots.push_back(predicted);
    else pending_snapshots.push_back(typed_snapshot(kind));

    roll = $urandom_range(0, 99);
    if (steady_flow || roll < 60) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else if (roll < 98) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver side: random stalls, one long hold-off on request, none during steady flow.
  initial begin : result_receiver
    int roll;
    int span;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (steady_flow) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          out_stall <= 1'b0;
          span = $urandom_range(1, 20);
        end else if (roll < 90) begin
          out_stall <= 1'b1;
          span = $urandom_range(1, 3);
        end else if (roll < 98) begin
          out_stall <= 1'b1;
          span = $urandom_range(4, 10);
        end else begin
          out_stall <= 1'b1;
          span = $urandom_range(30, 80);
        end
        repeat (span) @(posedge clk);
      end
    end
  end

  // Compare every accepted result with the oldest expected snapshot.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_snapshots.size() == 0) begin
        note_mismatch($sformatf("[tb] result %0d arrived with nothing expected", result_index));
      end else begin
        compare_field("status", out_status, pending_snapshots[0].status);
        compare_field("test_active", out_test_active, pending_snapshots[0].active);
        compare_field("test_completed", out_test_completed, pending_snapshots[0].completed);
        compare_field("done_event", out_done_event, pending_snapshots[0].done_evt);
        compare_field("samples_taken", out_samples_taken, pending_snapshots[0].taken);
        compare_field("samples_found", out_samples_found, pending_snapshots[0].found);
        compare_field("samples_lost", out_samples_lost, pending_snapshots[0].lost);
        compare_field("sign_crossings", out_sign_crossings, pending_snapshots[0].crossings);
        compare_field("absolute_error_total", out_absolute_error_total,
                      pending_snapshots[0].abs_total);
        compare_field("smallest_error", out_smallest_error, pending_snapshots[0].smallest);
        compare_field("largest_error", out_largest_error, pending_snapshots[0].largest);
        compare_field("mean_absolute_error", out_mean_absolute_error,
                      pending_snapshots[0].mean);
        void'(pending_snapshots.pop_front());
      end
      result_index++;
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[tb] timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_snapshots.size());
      $display("[line_error_test_statistics] ERROR");
      $finish;
    end
  end

  // Main sequence: reset, opening table, random tests, drain.
  initial begin : stimulus
    logic [ACT_WIDTH-1:0] act;
    logic [DUR_WIDTH-1:0] dur;
    logic found;
    logic signed [ERROR_WIDTH-1:0] err;
    int roll;
    int item_index;
    int counted_items;
    bit ignored;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening table.
    foreach (opening_plan[i]) begin
      offer_transaction(opening_plan[i].action, opening_plan[i].duration,
                        opening_plan[i].line_found, opening_plan[i].error,
                        opening_plan[i].check);
    end

    // Random tests: mostly short well-formed runs, with stops, restarts and noise.
    item_index = 0;
    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      if (item_index == 300) hold_request = 1'b1;
      if (item_index == 900) begin
        in_valid <= 1'b0;
        while (pending_snapshots.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      steady_flow = (item_index >= 1100 && item_index < 1300);

      roll = $urandom_range(0, 99);
      if (run_armed) begin
        if (roll < 58) act = ACT_TICK;
        else if (roll < 93) act = ACT_SAMPLE;
        else if (roll < 94) act = ACT_STOP;
        else if (roll < 95) act = ACT_START;
        else act = ACT_READ + ACT_WIDTH'($urandom_range(0, 3));
      end else begin
        if (roll < 70) act = ACT_START;
        else if (roll < 80) act = ACT_SAMPLE;
        else if (roll < 88) act = ACT_TICK;
        else if (roll < 92) act = ACT_STOP;
        else act = ACT_READ + ACT_WIDTH'($urandom_range(0, 3));
      end

      roll = $urandom_range(0, 99);
      if (roll < 75) dur = MIN_DURATION_MS + DUR_WIDTH'($urandom_range(0, 12));
      else if (roll < 85) dur = DUR_WIDTH'($urandom_range(200, 10000));
      else dur = DUR_WIDTH'($urandom_range(0, 16383));

      found = ($urandom_range(0, 99) < 80);
      roll = $urandom_range(0, 9);
      if (roll < 6) begin
        err = ERROR_WIDTH'($urandom);
      end else if (roll < 8) begin
        err = ERROR_WIDTH'(int'($urandom_range(0, 32)) - 16);
      end else begin
        case ($urandom_range(0, 3))
          0: err = {1'b1, {(ERROR_WIDTH-1){1'b0}}};
          1: err = {1'b0, {(ERROR_WIDTH-1){1'b1}}};
          2: err = '0;
          default: err = '1;
        endcase
      end

      ignored = !run_armed && (act == ACT_SAMPLE || act == ACT_TICK);
      offer_transaction(act, dur, found, err, CHECK_MODEL);
      if (!ignored) counted_items++;
      item_index++;
    end

    // Drain and let the block settle.
    in_valid <= 1'b0;
    steady_flow = 1'b0;
    while (pending_snapshots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("[tb] %0d transactions checked: %0d starts taken, %0d refused, %0d tests ran out",
             result_index, starts_taken, starts_refused, tests_completed);
    $display("[tb] %0d samples with a line recorded, %0d mismatches",
             found_recorded, mismatch_count);
    if (mismatch_count == 0 && pending_snapshots.size() == 0) begin
      $display("[line_error_test_statistics] OK");
    end else begin
      $display("[line_error_test_statistics] ERROR");
    end
    $finish;
  end

endmodule
